FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, inactive during reset.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Next-cycle implication that is also checked across reset.
`define CHK_NEXT_RAW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("next-cycle implication across reset failed");

`endif

FILE: sv/pslt_pkg.sv
package pslt_pkg;

    localparam logic [1:0] FN_OBSERVE  = 2'd0;
    localparam logic [1:0] FN_FINALIZE = 2'd1;
    localparam logic [1:0] FN_FLUSH    = 2'd2;
    localparam logic [1:0] FN_RESTART  = 2'd3;

    localparam logic [1:0] CR_STREAM     = 2'd0;
    localparam logic [1:0] CR_INIT_VALID = 2'd1;
    localparam logic [1:0] CR_INIT_SEQ   = 2'd2;
    localparam logic [1:0] CR_MAX_JUMP   = 2'd3;

    localparam logic [2:0] C_FIN     = 3'd0;
    localparam logic [2:0] C_LOST    = 3'd1;
    localparam logic [2:0] C_UNIQ    = 3'd2;
    localparam logic [2:0] C_DUP     = 3'd3;
    localparam logic [2:0] C_REORD   = 3'd4;
    localparam logic [2:0] C_LATE    = 3'd5;
    localparam logic [2:0] C_FOREIGN = 3'd6;
    localparam logic [2:0] C_JUMP    = 3'd7;

    typedef enum logic [2:0] {
        D_UNINIT  = 3'd0,
        D_FOREIGN = 3'd1,
        D_INORDER = 3'd2,
        D_LATE    = 3'd3,
        D_JUMP    = 3'd4,
        D_DUP     = 3'd5,
        D_REORD   = 3'd6
    } t_disp;

    typedef enum logic [2:0] {
        K_OBS,
        K_FOREIGN,
        K_FIN,
        K_FLUSH,
        K_RESTART
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OBS1,
        ST_OBS2,
        ST_OBS3,
        ST_FCHK,
        ST_ADV,
        ST_EXCESS,
        ST_WALK,
        ST_LOOK,
        ST_DEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] packet_stream;
        logic [63:0] sequence_req;
    } t_in;

    typedef struct packed {
        logic [2:0]  disposition;
        logic        accepted;
        logic [31:0] generation_out;
        logic [63:0] finalized_total;
        logic [63:0] lost_total;
        logic [63:0] unique_total;
        logic [63:0] duplicate_total;
        logic [63:0] reordered_total;
        logic [63:0] late_total;
        logic [63:0] foreign_total;
        logic [63:0] jump_total;
    } t_out;

    typedef struct packed {
        logic [31:0] tracked_stream;
        logic        preset_valid;
        logic [63:0] preset_seq;
        logic [63:0] jump_limit;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] seq;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q;

    typedef struct packed {
        logic pop;
        logic hold;
    } t_bk;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] sat_inc(input logic [63:0] a);
        return sat_add(a, 64'd1);
    endfunction

endpackage

FILE: sv/pslt_front.sv
module pslt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pslt_pkg::t_in     i_in_data,
    input  logic [31:0]       i_tracked_stream,
    input  pslt_pkg::t_bk     i_bk,
    output pslt_pkg::t_q      o_q
);

    pslt_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    pslt_pkg::t_cmd c_cmd;
    logic           c_push;
    logic           c_pop;

    always_comb begin
        c_cmd.seq = i_in_data.sequence_req;
        unique case (i_in_data.func)
            pslt_pkg::FN_OBSERVE: begin
                c_cmd.kind = (i_in_data.packet_stream == i_tracked_stream) ?
                             pslt_pkg::K_OBS : pslt_pkg::K_FOREIGN;
            end
            pslt_pkg::FN_FINALIZE: c_cmd.kind = pslt_pkg::K_FIN;
            pslt_pkg::FN_FLUSH:    c_cmd.kind = pslt_pkg::K_FLUSH;
            default:               c_cmd.kind = pslt_pkg::K_RESTART;
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2) || i_bk.hold;
    assign c_push     = i_in_valid && !o_in_stall;
    assign c_pop      = i_bk.pop && (r_cnt != 2'd0);
    assign o_q.valid  = (r_cnt != 2'd0);
    assign o_q.cmd    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_q[r_wp] <= c_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) begin
                r_wp <= ~r_wp;
            end
            if (c_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(c_push) - 2'(c_pop);
        end
    end

endmodule

FILE: sv/pslt_back.sv
module pslt_back #(
    parameter int WINDOW = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pslt_pkg::t_cfg    i_cfg,
    input  pslt_pkg::t_q      i_q,
    output pslt_pkg::t_bk     o_bk,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pslt_pkg::t_out    o_out_data
);

    localparam int          AW    = $clog2(WINDOW);
    localparam int          AWP   = AW + 1;
    localparam logic [63:0] WIN64 = 64'(WINDOW);
    localparam logic [63:0] WM1   = 64'(WINDOW - 1);
    localparam logic [AW:0] WCNT  = AWP'(WINDOW);

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] a);
        return (a == AW'(WINDOW - 1)) ? '0 : a + AW'(1);
    endfunction

    pslt_pkg::t_state r_state;
    pslt_pkg::t_state n_state;

    logic             r_mem [WINDOW];
    logic             r_rd;
    logic [AW-1:0]    r_head;
    logic [63:0]      r_base;
    logic [63:0]      r_high;
    logic             r_ready;
    logic             r_known;
    logic             r_any;
    logic [31:0]      r_gen;
    logic [63:0]      r_cnt [8];
    pslt_pkg::t_cmd   r_cmd;
    logic [63:0]      r_diff;
    logic [63:0]      r_off;
    logic [63:0]      r_delta;
    logic [63:0]      r_ex;
    logic             r_gt_ref;
    logic             r_below;
    logic             r_gt_high;
    logic             r_full;
    logic             r_acc;
    pslt_pkg::t_disp  r_disp;
    logic [AW-1:0]    r_walk_addr;
    logic [AW:0]      r_left;
    logic             r_wv;
    logic [AW-1:0]    r_wa;
    logic             r_rst_clear;
    logic             r_ov;
    pslt_pkg::t_out   r_out;

    logic [63:0]      c_ref;
    logic [63:0]      c_jump;
    logic             c_late;
    logic             c_jump_bad;
    logic             c_off_big;
    logic             c_fin_ok;
    logic             c_fl_ok;
    logic             c_adv_ok;
    logic             c_full;
    logic             c_walk_done;
    logic             c_out_free;
    logic [AW:0]      c_sum;
    logic [AW-1:0]    c_slot;
    logic             c_first;
    logic [AW-1:0]    c_rd_addr;
    logic             c_we;
    logic [AW-1:0]    c_wa;
    logic             c_wd;

    assign c_ref       = r_any ? r_high : r_base;
    assign c_jump      = (i_cfg.jump_limit == 64'd0) ? 64'd1 : i_cfg.jump_limit;
    assign c_late      = r_cmd.seq < r_base;
    assign c_jump_bad  = r_gt_ref && (r_diff > c_jump);
    assign c_off_big   = r_off >= WIN64;
    assign c_fin_ok    = r_any && (r_cmd.seq >= r_base) && (r_cmd.seq <= r_high);
    assign c_fl_ok     = r_any && (r_high >= r_base);
    assign c_adv_ok    = (r_cmd.kind == pslt_pkg::K_FIN) ? c_fin_ok : c_fl_ok;
    assign c_full      = r_delta >= WM1;
    assign c_walk_done = (r_left == '0) && !r_wv;
    assign c_out_free  = !r_ov || !i_out_stall;
    assign c_sum       = {1'b0, r_head} + {1'b0, r_off[AW-1:0]};
    assign c_slot      = (c_sum >= WCNT) ? AW'(c_sum - WCNT) : c_sum[AW-1:0];
    assign c_first     = r_ready && (r_cmd.kind == pslt_pkg::K_OBS) && !r_known;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pslt_pkg::ST_CLEAR: begin
                if (r_left == AWP'(1)) begin
                    n_state = r_rst_clear ? pslt_pkg::ST_IDLE : pslt_pkg::ST_DONE;
                end
            end
            pslt_pkg::ST_IDLE: begin
                if (i_q.valid) begin
                    unique case (i_q.cmd.kind)
                        pslt_pkg::K_OBS, pslt_pkg::K_FOREIGN: n_state = pslt_pkg::ST_OBS1;
                        pslt_pkg::K_FIN, pslt_pkg::K_FLUSH:   n_state = pslt_pkg::ST_FCHK;
                        default:                              n_state = pslt_pkg::ST_CLEAR;
                    endcase
                end
            end
            pslt_pkg::ST_OBS1: begin
                if (!r_ready || r_cmd.kind == pslt_pkg::K_FOREIGN || !r_known || c_late) begin
                    n_state = pslt_pkg::ST_DONE;
                end else begin
                    n_state = pslt_pkg::ST_OBS2;
                end
            end
            pslt_pkg::ST_OBS2:   n_state = c_jump_bad ? pslt_pkg::ST_DONE : pslt_pkg::ST_OBS3;
            pslt_pkg::ST_OBS3:   n_state = c_off_big ? pslt_pkg::ST_ADV : pslt_pkg::ST_LOOK;
            pslt_pkg::ST_FCHK:   n_state = c_adv_ok ? pslt_pkg::ST_ADV : pslt_pkg::ST_DONE;
            pslt_pkg::ST_ADV:    n_state = pslt_pkg::ST_EXCESS;
            pslt_pkg::ST_EXCESS: n_state = pslt_pkg::ST_WALK;
            pslt_pkg::ST_WALK: begin
                if (c_walk_done) begin
                    n_state = (r_cmd.kind == pslt_pkg::K_OBS) ?
                              pslt_pkg::ST_LOOK : pslt_pkg::ST_DONE;
                end
            end
            pslt_pkg::ST_LOOK:   n_state = pslt_pkg::ST_DEC;
            pslt_pkg::ST_DEC:    n_state = pslt_pkg::ST_DONE;
            pslt_pkg::ST_DONE:   n_state = c_out_free ? pslt_pkg::ST_IDLE : pslt_pkg::ST_DONE;
            default:             n_state = pslt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_bk.pop  = (r_state == pslt_pkg::ST_IDLE);
        o_bk.hold = (r_state == pslt_pkg::ST_CLEAR);
        c_rd_addr = r_walk_addr;
        c_we      = 1'b0;
        c_wa      = r_wa;
        c_wd      = 1'b0;
        unique case (r_state)
            pslt_pkg::ST_CLEAR: begin
                c_we = 1'b1;
                c_wa = r_walk_addr;
            end
            pslt_pkg::ST_OBS1: begin
                if (c_first) begin
                    c_we = 1'b1;
                    c_wa = r_head;
                    c_wd = 1'b1;
                end
            end
            pslt_pkg::ST_WALK: begin
                c_we = r_wv;
            end
            pslt_pkg::ST_LOOK: begin
                c_rd_addr = c_slot;
            end
            pslt_pkg::ST_DEC: begin
                c_we = !r_rd;
                c_wd = 1'b1;
            end
            default: begin
                c_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_mem[c_wa] <= c_wd;
        end
        r_rd <= r_mem[c_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pslt_pkg::ST_CLEAR;
            r_left      <= WCNT;
            r_walk_addr <= '0;
            r_rst_clear <= 1'b1;
            r_head      <= '0;
            r_base      <= '0;
            r_high      <= '0;
            r_ready     <= 1'b0;
            r_known     <= 1'b0;
            r_any       <= 1'b0;
            r_gen       <= '0;
            r_ov        <= 1'b0;
            r_wv        <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == pslt_pkg::ST_DONE && c_out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                pslt_pkg::ST_CLEAR: begin
                    r_walk_addr <= f_next(r_walk_addr);
                    r_left      <= r_left - AWP'(1);
                end
                pslt_pkg::ST_IDLE: begin
                    if (i_q.valid) begin
                        r_cmd  <= i_q.cmd;
                        r_acc  <= (i_q.cmd.kind == pslt_pkg::K_RESTART);
                        r_disp <= pslt_pkg::D_UNINIT;
                        if (i_q.cmd.kind == pslt_pkg::K_RESTART) begin
                            r_rst_clear <= 1'b0;
                            r_left      <= WCNT;
                            r_walk_addr <= '0;
                            r_head      <= '0;
                            r_base      <= i_cfg.preset_valid ?
                                           i_cfg.preset_seq : 64'd0;
                            r_high      <= i_cfg.preset_valid ?
                                           i_cfg.preset_seq : 64'd0;
                            r_gen       <= r_gen + 32'd1;
                            r_ready     <= 1'b1;
                            r_known     <= i_cfg.preset_valid;
                            r_any       <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_cnt[i] <= '0;
                            end
                        end
                    end
                end
                pslt_pkg::ST_OBS1: begin
                    if (r_ready) begin
                        if (r_cmd.kind == pslt_pkg::K_FOREIGN) begin
                            r_cnt[pslt_pkg::C_FOREIGN] <=
                                pslt_pkg::sat_inc(r_cnt[pslt_pkg::C_FOREIGN]);
                            r_disp <= pslt_pkg::D_FOREIGN;
                        end else if (!r_known) begin
                            r_known <= 1'b1;
                            r_any   <= 1'b1;
                            r_base  <= r_cmd.seq;
                            r_high  <= r_cmd.seq;
                            r_cnt[pslt_pkg::C_UNIQ] <=
                                pslt_pkg::sat_inc(r_cnt[pslt_pkg::C_UNIQ]);
                            r_disp  <= pslt_pkg::D_INORDER;
                        end else if (c_late) begin
                            r_cnt[pslt_pkg::C_LATE] <=
                                pslt_pkg::sat_inc(r_cnt[pslt_pkg::C_LATE]);
                            r_disp <= pslt_pkg::D_LATE;
                        end
                    end
                    r_diff    <= r_cmd.seq - c_ref;
                    r_gt_ref  <= r_cmd.seq > c_ref;
                    r_below   <= r_any && (r_cmd.seq < r_high);
                    r_gt_high <= r_cmd.seq > r_high;
                end
                pslt_pkg::ST_OBS2: begin
                    if (c_jump_bad) begin
                        r_cnt[pslt_pkg::C_JUMP] <= pslt_pkg::sat_inc(r_cnt[pslt_pkg::C_JUMP]);
                        r_disp <= pslt_pkg::D_JUMP;
                    end
                    r_off <= r_cmd.seq - r_base;
                end
                pslt_pkg::ST_OBS3: begin
                    r_delta <= r_off - WIN64;
                end
                pslt_pkg::ST_FCHK: begin
                    if (r_cmd.kind == pslt_pkg::K_FIN) begin
                        r_acc   <= c_fin_ok;
                        r_delta <= r_cmd.seq - r_base;
                    end else begin
                        r_acc   <= 1'b1;
                        r_delta <= r_high - r_base;
                    end
                end
                pslt_pkg::ST_ADV: begin
                    r_full <= c_full;
                    r_ex   <= r_delta - WM1;
                    r_base <= r_base + r_delta + 64'd1;
                    r_wv   <= 1'b0;
                    if (c_full) begin
                        r_walk_addr <= '0;
                        r_left      <= WCNT;
                    end else begin
                        r_walk_addr <= r_head;
                        r_left      <= {1'b0, r_delta[AW-1:0]} + AWP'(1);
                    end
                end
                pslt_pkg::ST_EXCESS: begin
                    if (r_full) begin
                        r_cnt[pslt_pkg::C_LOST] <=
                            pslt_pkg::sat_add(r_cnt[pslt_pkg::C_LOST], r_ex);
                    end
                end
                pslt_pkg::ST_WALK: begin
                    if (r_left != '0) begin
                        r_wa        <= r_walk_addr;
                        r_walk_addr <= f_next(r_walk_addr);
                        r_left      <= r_left - AWP'(1);
                        r_wv        <= 1'b1;
                    end else begin
                        r_wv <= 1'b0;
                    end
                    if (r_wv) begin
                        if (r_rd) begin
                            r_cnt[pslt_pkg::C_FIN] <=
                                pslt_pkg::sat_inc(r_cnt[pslt_pkg::C_FIN]);
                        end else begin
                            r_cnt[pslt_pkg::C_LOST] <=
                                pslt_pkg::sat_inc(r_cnt[pslt_pkg::C_LOST]);
                        end
                    end
                    if (c_walk_done) begin
                        r_head <= r_walk_addr;
                        r_off  <= WM1;
                    end
                end
                pslt_pkg::ST_LOOK: begin
                    r_wa <= c_slot;
                end
                pslt_pkg::ST_DEC: begin
                    if (r_rd) begin
                        r_cnt[pslt_pkg::C_DUP] <= pslt_pkg::sat_inc(r_cnt[pslt_pkg::C_DUP]);
                        r_disp <= pslt_pkg::D_DUP;
                    end else begin
                        r_cnt[pslt_pkg::C_UNIQ] <= pslt_pkg::sat_inc(r_cnt[pslt_pkg::C_UNIQ]);
                        if (!r_any || r_gt_high) begin
                            r_high <= r_cmd.seq;
                        end
                        r_any <= 1'b1;
                        if (r_below) begin
                            r_cnt[pslt_pkg::C_REORD] <=
                                pslt_pkg::sat_inc(r_cnt[pslt_pkg::C_REORD]);
                            r_disp <= pslt_pkg::D_REORD;
                        end else begin
                            r_disp <= pslt_pkg::D_INORDER;
                        end
                    end
                end
                default: begin
                    r_wv <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pslt_pkg::ST_DONE && c_out_free) begin
            r_out.disposition     <= r_disp;
            r_out.accepted        <= r_acc;
            r_out.generation_out  <= r_gen;
            r_out.finalized_total <= r_cnt[pslt_pkg::C_FIN];
            r_out.lost_total      <= r_cnt[pslt_pkg::C_LOST];
            r_out.unique_total    <= r_cnt[pslt_pkg::C_UNIQ];
            r_out.duplicate_total <= r_cnt[pslt_pkg::C_DUP];
            r_out.reordered_total <= r_cnt[pslt_pkg::C_REORD];
            r_out.late_total      <= r_cnt[pslt_pkg::C_LATE];
            r_out.foreign_total   <= r_cnt[pslt_pkg::C_FOREIGN];
            r_out.jump_total      <= r_cnt[pslt_pkg::C_JUMP];
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

FILE: sv/packet_sequence_loss_tracker.sv
// Receive-side sequence tracker with a WINDOW-slot bitmap held in one memory. An observe that
// first moves the window walks the freed slots before it looks up its own slot, and a finalize
// or flush that moves the window walks the freed slots; a move of a whole window or more walks
// all WINDOW slots, one memory read per cycle. A rejected observe, one whose forward jump is too
// large, and a refused finalize end without moving the window. A restart, and reset, run a
// clearing pass over all WINDOW slots of the bitmap during which no transfer is taken on the
// input. A two-entry queue decouples input transfers from the engine.
module packet_sequence_loss_tracker #(
    parameter int WINDOW = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pslt_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pslt_pkg::t_out    o_out_data
);

    pslt_pkg::t_cfg r_cfg;
    pslt_pkg::t_q   w_q;
    pslt_pkg::t_bk  w_bk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tracked_stream <= '0;
            r_cfg.preset_valid   <= 1'b0;
            r_cfg.preset_seq     <= '0;
            r_cfg.jump_limit     <= 64'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pslt_pkg::CR_STREAM:     r_cfg.tracked_stream <= i_cfg_data[31:0];
                pslt_pkg::CR_INIT_VALID: r_cfg.preset_valid <= i_cfg_data[0];
                pslt_pkg::CR_INIT_SEQ:   r_cfg.preset_seq <= i_cfg_data;
                pslt_pkg::CR_MAX_JUMP:   r_cfg.jump_limit <= i_cfg_data;
                default:                 r_cfg.jump_limit <= r_cfg.jump_limit;
            endcase
        end
    end

    pslt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_data        (i_in_data),
        .i_tracked_stream (r_cfg.tracked_stream),
        .i_bk             (w_bk),
        .o_q              (w_q)
    );

    pslt_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q         (w_q),
        .o_bk        (w_bk),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: sv/pslt_chk.sv
`include "assert_macros.svh"

module pslt_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input pslt_pkg::t_out o_out_data
);

    // No result is shown in the cycle after reset.
    `CHK_NEXT_RAW(a_rst_quiet, !i_rst_n, !o_out_valid)

    // A stalled result stays offered.
    `CHK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // Only an observe has a disposition, and an observe is never accepted.
    `CHK_IMPL(a_disp_acc, o_out_valid && o_out_data.accepted, o_out_data.disposition == pslt_pkg::D_UNINIT)

endmodule

bind packet_sequence_loss_tracker pslt_chk u_pslt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
